@@ rtl/rslnf_pkg.sv @@
// Shared constants, codes and character helpers for the route string loop neighbor finder.
`default_nettype none

package rslnf_pkg;

    localparam int FAILED_SET_DEPTH = 16;
    localparam int SET_IW = $clog2(FAILED_SET_DEPTH);
    localparam int SET_CW = $clog2(FAILED_SET_DEPTH + 1);

    localparam int NODE_W  = 64;
    localparam int COUNT_W = 16;
    localparam int ERR_W   = 2;

    typedef logic [NODE_W-1:0]  t_node;
    typedef logic [COUNT_W-1:0] t_count;
    typedef logic [ERR_W-1:0]   t_err;

    localparam logic KIND_NODE    = 1'b0;
    localparam logic KIND_SUMMARY = 1'b1;

    localparam t_err ERR_OK       = 2'd0;
    localparam t_err ERR_OWN_ZERO = 2'd1;
    localparam t_err ERR_SET_FULL = 2'd2;

    localparam logic [4:0] DIGIT_NONE = 5'd31;

    localparam logic [7:0] CH_NUL  = 8'h00;
    localparam logic [7:0] CH_I    = 8'h69;
    localparam logic [7:0] CH_P    = 8'h70;
    localparam logic [7:0] CH_N    = 8'h6E;
    localparam logic [7:0] CH_COLON = 8'h3A;
    localparam logic [7:0] CH_X_LO = 8'h78;
    localparam logic [7:0] CH_X_UP = 8'h58;

    // digit value in any base up to 16, DIGIT_NONE otherwise
    function automatic logic [4:0] rslnf_digit(input logic [7:0] c);
        logic [4:0] d;
        begin
            d = DIGIT_NONE;
            if (c >= 8'h30 && c <= 8'h39) begin
                d = 5'(c - 8'h30);
            end else if (c >= 8'h61 && c <= 8'h66) begin
                d = 5'(c - 8'h57);
            end else if (c >= 8'h41 && c <= 8'h46) begin
                d = 5'(c - 8'h37);
            end
            return d;
        end
    endfunction

    // characters of the "ipn:" tag
    function automatic logic [7:0] rslnf_tag_char(input logic [1:0] p);
        logic [7:0] c;
        begin
            case (p)
                2'd0: begin
                    c = CH_I;
                end
                2'd1: begin
                    c = CH_P;
                end
                2'd2: begin
                    c = CH_N;
                end
                default: begin
                    c = CH_COLON;
                end
            endcase
            return c;
        end
    endfunction

endpackage

`default_nettype wire

@@ rtl/rslnf_if.sv @@
// Channel interfaces: route string bytes in, node and summary results out.
`default_nettype none

interface rslnf_in_if;
    import rslnf_pkg::*;

    logic       valid;
    logic       ready;
    logic [7:0] ch;
    logic       last;

    modport source (output valid, output ch, output last, input ready);
    modport sink (input valid, input ch, input last, output ready);
endinterface

interface rslnf_out_if;
    import rslnf_pkg::*;

    logic   valid;
    logic   ready;
    logic   kind;
    t_node  node_value;
    t_count route_position;
    logic   follows_own_node;
    logic   newly_recorded;
    t_count route_length;
    t_count failed_count;
    t_err   error_code;
    logic   last_result;

    modport source (
        output valid, output kind, output node_value, output route_position,
        output follows_own_node, output newly_recorded, output route_length,
        output failed_count, output error_code, output last_result,
        input ready
    );
    modport sink (
        input valid, input kind, input node_value, input route_position,
        input follows_own_node, input newly_recorded, input route_length,
        input failed_count, input error_code, input last_result,
        output ready
    );
endinterface

`default_nettype wire

@@ rtl/route_string_loop_neighbor_finder_core.sv @@
// Route string loop neighbor finder: parses "ipn:" node numbers and tracks own-node neighbors.
//
// Bytes of a route string arrive one per beat on i_item; every "ipn:<number>" yields
// a node beat on o_result (number read with automatic base, saturated to 64 bits),
// unless it repeats the previous node, and the beat flagged last also yields one
// summary beat. Nodes that directly follow own node (i_cfg_data, written via
// i_cfg_we) go into a failed-neighbor set held in a FAILED_SET_DEPTH-entry memory.
// Each byte passes through ST_IDLE and ST_NODE; a byte that yields a node beat then
// passes ST_EMIT, and the last byte ends in ST_SUM for the summary. A node that
// follows own node first passes ST_SEARCH, where the set is searched one entry
// per cycle through the memory's single read port. Each beat also waits while the
// previous one is still held on o_result. The result register lets a new byte be
// taken while a beat waits on o_result; the set needs no clearing after reset.
`default_nettype none

module route_string_loop_neighbor_finder_core (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    rslnf_in_if.sink                i_item,
    rslnf_out_if.source             o_result,
    input  wire logic               i_cfg_we,
    input  wire rslnf_pkg::t_node   i_cfg_data
);
    import rslnf_pkg::*;

    localparam logic [2:0] ST_IDLE   = 3'd0;
    localparam logic [2:0] ST_NODE   = 3'd1;
    localparam logic [2:0] ST_SEARCH = 3'd2;
    localparam logic [2:0] ST_EMIT   = 3'd3;
    localparam logic [2:0] ST_SUM    = 3'd4;

    localparam logic [2:0] M_SEARCH     = 3'd0;
    localparam logic [2:0] M_AFTER_TAG  = 3'd1;
    localparam logic [2:0] M_FIRST_ZERO = 3'd2;
    localparam logic [2:0] M_HEX_PREFIX = 3'd3;
    localparam logic [2:0] M_DEC        = 3'd4;
    localparam logic [2:0] M_OCT        = 3'd5;
    localparam logic [2:0] M_HEX        = 3'd6;
    localparam logic [2:0] M_STOP       = 3'd7;

    logic [2:0]        r_state, n_state;
    logic [1:0]        r_prog, n_prog;
    logic [2:0]        r_mode, n_mode;
    t_node             r_acc, n_acc;
    t_node             r_prev, n_prev;
    t_count            r_kept, n_kept;
    logic              r_expect, n_expect;
    t_count            r_hits, n_hits;
    logic [SET_CW-1:0] r_used, n_used;
    logic              r_ovf, n_ovf;
    t_node             r_own;
    logic              r_fin, n_fin;
    logic              r_last, n_last;
    t_node             r_val, n_val;
    logic [SET_CW-1:0] r_idx, n_idx;
    logic              r_chk, n_chk;
    logic              r_follows, n_follows;
    logic              r_added, n_added;
    logic              r_o_valid, n_o_valid;

    logic              r_o_kind;
    t_node             r_o_node;
    t_count            r_o_pos;
    logic              r_o_follows;
    logic              r_o_added;
    t_count            r_o_len;
    t_count            r_o_failed;
    t_err              r_o_err;
    logic              r_o_last;

    t_node             r_set_mem [FAILED_SET_DEPTH];
    t_node             r_set_rdata;

    logic [4:0]        w_d;
    logic [4:0]        w_base;
    logic [67:0]       w_prod;
    logic [67:0]       w_sum;
    t_node             w_mac;
    logic              w_digit_ok;
    logic              w_in_num;
    logic              w_tag;
    logic              w_out_free;
    logic              w_set_we;
    logic              w_load_node;
    logic              w_load_sum;
    logic              w_hit;

    assign i_item.ready = (r_state == ST_IDLE);
    assign w_out_free   = !r_o_valid || o_result.ready;
    assign w_d          = rslnf_digit(i_item.ch);
    assign w_in_num     = (r_mode == M_FIRST_ZERO) || (r_mode == M_HEX_PREFIX) ||
                          (r_mode == M_DEC) || (r_mode == M_OCT) || (r_mode == M_HEX);
    assign w_hit        = r_chk && (r_set_rdata == r_val);

    // saturating acc * base + digit
    always_comb begin
        case (r_mode)
            M_DEC: begin
                w_base = 5'd10;
                w_prod = {1'b0, r_acc, 3'b000} + {3'b000, r_acc, 1'b0};
            end
            M_OCT: begin
                w_base = 5'd8;
                w_prod = {1'b0, r_acc, 3'b000};
            end
            default: begin
                w_base = 5'd16;
                w_prod = {r_acc, 4'b0000};
            end
        endcase
        w_sum      = w_prod + {64'd0, w_d[3:0]};
        w_mac      = (|w_sum[67:64]) ? '1 : w_sum[63:0];
        w_digit_ok = (w_d < w_base);
    end

    always_comb begin
        n_state     = r_state;
        n_prog      = r_prog;
        n_mode      = r_mode;
        n_acc       = r_acc;
        n_prev      = r_prev;
        n_kept      = r_kept;
        n_expect    = r_expect;
        n_hits      = r_hits;
        n_used      = r_used;
        n_ovf       = r_ovf;
        n_fin       = r_fin;
        n_last      = r_last;
        n_val       = r_val;
        n_idx       = r_idx;
        n_chk       = r_chk;
        n_follows   = r_follows;
        n_added     = r_added;
        n_o_valid   = r_o_valid && !o_result.ready;
        w_tag       = 1'b0;
        w_set_we    = 1'b0;
        w_load_node = 1'b0;
        w_load_sum  = 1'b0;

        case (r_state)
            ST_IDLE: begin
                if (i_item.valid) begin
                    n_fin  = 1'b0;
                    n_val  = r_acc;
                    n_last = i_item.last;
                    if (i_item.ch == CH_NUL) begin
                        n_fin  = w_in_num;
                        n_acc  = '0;
                        n_mode = M_STOP;
                    end else begin
                        case (r_mode)
                            M_SEARCH: begin
                                w_tag = 1'b1;
                            end
                            M_AFTER_TAG: begin
                                if (w_d < 5'd10) begin
                                    n_acc  = NODE_W'(w_d);
                                    n_mode = (w_d == 5'd0) ? M_FIRST_ZERO : M_DEC;
                                end else begin
                                    n_mode = M_STOP;
                                end
                            end
                            M_FIRST_ZERO: begin
                                if (i_item.ch == CH_X_LO || i_item.ch == CH_X_UP) begin
                                    n_mode = M_HEX_PREFIX;
                                end else if (w_d < 5'd8) begin
                                    n_acc  = NODE_W'(w_d);
                                    n_mode = M_OCT;
                                end else begin
                                    n_fin = 1'b1;
                                    n_val = '0;
                                    w_tag = 1'b1;
                                end
                            end
                            M_HEX_PREFIX: begin
                                if (w_d < 5'd16) begin
                                    n_acc  = NODE_W'(w_d);
                                    n_mode = M_HEX;
                                end else begin
                                    n_fin = 1'b1;
                                    n_val = '0;
                                    w_tag = 1'b1;
                                end
                            end
                            M_DEC, M_OCT, M_HEX: begin
                                if (w_digit_ok) begin
                                    n_acc = w_mac;
                                end else begin
                                    n_fin = 1'b1;
                                    w_tag = 1'b1;
                                end
                            end
                            default: begin
                            end
                        endcase
                        if (n_fin) begin
                            n_mode = M_SEARCH;
                            n_acc  = '0;
                        end
                        if (w_tag) begin
                            if (i_item.ch == rslnf_tag_char(r_prog)) begin
                                if (r_prog == 2'd3) begin
                                    n_prog = 2'd0;
                                    n_mode = M_AFTER_TAG;
                                end else begin
                                    n_prog = r_prog + 2'd1;
                                end
                            end else begin
                                n_prog = (i_item.ch == CH_I) ? 2'd1 : 2'd0;
                            end
                        end
                    end
                    // a number still open on the final byte is closed here
                    if (i_item.last && !n_fin &&
                        (n_mode == M_FIRST_ZERO || n_mode == M_HEX_PREFIX ||
                         n_mode == M_DEC || n_mode == M_OCT || n_mode == M_HEX)) begin
                        n_fin = 1'b1;
                        n_val = n_acc;
                    end
                    n_state = ST_NODE;
                end
            end
            ST_NODE: begin
                if (r_fin && r_val != r_prev) begin
                    n_prev = r_val;
                    if (r_expect) begin
                        n_expect  = 1'b0;
                        n_follows = 1'b1;
                        if (r_hits != '1) begin
                            n_hits = r_hits + 16'd1;
                        end
                        n_idx   = '0;
                        n_chk   = 1'b0;
                        n_state = ST_SEARCH;
                    end else begin
                        n_expect  = (r_own != '0) && (r_val == r_own);
                        n_follows = 1'b0;
                        n_added   = 1'b0;
                        n_state   = ST_EMIT;
                    end
                end else begin
                    n_state = r_last ? ST_SUM : ST_IDLE;
                end
            end
            ST_SEARCH: begin
                n_chk = 1'b0;
                if (w_hit) begin
                    n_added = 1'b0;
                    n_state = ST_EMIT;
                end else if (r_idx == r_used) begin
                    if (r_used < SET_CW'(FAILED_SET_DEPTH)) begin
                        w_set_we = 1'b1;
                        n_used   = r_used + SET_CW'(1);
                        n_added  = 1'b1;
                    end else begin
                        n_ovf   = 1'b1;
                        n_added = 1'b0;
                    end
                    n_state = ST_EMIT;
                end else begin
                    n_idx = r_idx + SET_CW'(1);
                    n_chk = 1'b1;
                end
            end
            ST_EMIT: begin
                if (w_out_free) begin
                    w_load_node = 1'b1;
                    n_o_valid   = 1'b1;
                    if (r_kept != '1) begin
                        n_kept = r_kept + 16'd1;
                    end
                    n_state = r_last ? ST_SUM : ST_IDLE;
                end
            end
            ST_SUM: begin
                if (w_out_free) begin
                    w_load_sum = 1'b1;
                    n_o_valid  = 1'b1;
                    n_prog     = 2'd0;
                    n_mode     = M_SEARCH;
                    n_acc      = '0;
                    n_prev     = '0;
                    n_kept     = '0;
                    n_expect   = 1'b0;
                    n_hits     = '0;
                    n_used     = '0;
                    n_ovf      = 1'b0;
                    n_state    = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= ST_IDLE;
            r_prog    <= 2'd0;
            r_mode    <= M_SEARCH;
            r_acc     <= '0;
            r_prev    <= '0;
            r_kept    <= '0;
            r_expect  <= 1'b0;
            r_hits    <= '0;
            r_used    <= '0;
            r_ovf     <= 1'b0;
            r_own     <= '0;
            r_fin     <= 1'b0;
            r_last    <= 1'b0;
            r_chk     <= 1'b0;
            r_o_valid <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_prog    <= n_prog;
            r_mode    <= n_mode;
            r_acc     <= n_acc;
            r_prev    <= n_prev;
            r_kept    <= n_kept;
            r_expect  <= n_expect;
            r_hits    <= n_hits;
            r_used    <= n_used;
            r_ovf     <= n_ovf;
            r_fin     <= n_fin;
            r_last    <= n_last;
            r_chk     <= n_chk;
            r_o_valid <= n_o_valid;
            if (i_cfg_we) begin
                r_own <= i_cfg_data;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_val     <= n_val;
        r_idx     <= n_idx;
        r_follows <= n_follows;
        r_added   <= n_added;
        if (w_load_node) begin
            r_o_kind    <= KIND_NODE;
            r_o_node    <= r_val;
            r_o_pos     <= r_kept;
            r_o_follows <= r_follows;
            r_o_added   <= r_added;
            r_o_len     <= '0;
            r_o_failed  <= '0;
            r_o_err     <= ERR_OK;
            r_o_last    <= 1'b0;
        end else if (w_load_sum) begin
            r_o_kind    <= KIND_SUMMARY;
            r_o_node    <= '0;
            r_o_pos     <= '0;
            r_o_follows <= 1'b0;
            r_o_added   <= 1'b0;
            r_o_len     <= r_kept;
            r_o_failed  <= r_hits;
            r_o_err     <= (r_own == '0) ? ERR_OWN_ZERO : (r_ovf ? ERR_SET_FULL : ERR_OK);
            r_o_last    <= 1'b1;
        end
    end

    // failed-neighbor set
    always_ff @(posedge i_clk) begin
        if (w_set_we) begin
            r_set_mem[r_used[SET_IW-1:0]] <= r_val;
        end
        r_set_rdata <= r_set_mem[r_idx[SET_IW-1:0]];
    end

    assign o_result.valid            = r_o_valid;
    assign o_result.kind             = r_o_kind;
    assign o_result.node_value       = r_o_node;
    assign o_result.route_position   = r_o_pos;
    assign o_result.follows_own_node = r_o_follows;
    assign o_result.newly_recorded   = r_o_added;
    assign o_result.route_length     = r_o_len;
    assign o_result.failed_count     = r_o_failed;
    assign o_result.error_code       = r_o_err;
    assign o_result.last_result      = r_o_last;

endmodule

`default_nettype wire
